/* src/sobel_pkg.sv */
// shared types and constants for the sobel edge block
package sobel_pkg;
  localparam int MaxWidth = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColBits = $clog2(MaxWidth);
  localparam int RowBits = $clog2(MaxHeight) + 1;
  localparam int CfgBits = 11;
  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       drain;
  } in_t;

  typedef struct packed {
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       frame_end;
  } out_t;

  // one window job for the back end: nine pixels, zero padding already applied
  typedef struct packed {
    logic [8:0][23:0] nb;
    logic             last;
  } job_t;
endpackage

/* src/sobel_front.sv */
// front end: line stores, 3x3 window, position counters and padding
module sobel_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [sobel_pkg::CfgBits-1:0] cfg_data,
  input  logic                          in_valid,
  input  sobel_pkg::in_t                in_data,
  output logic                          in_stall,
  output logic                          job_valid,
  output sobel_pkg::job_t               job,
  input  logic                          job_stall
);
  localparam int CB = sobel_pkg::ColBits;
  localparam int RB = sobel_pkg::RowBits;

  logic [sobel_pkg::CfgBits-1:0] image_width, image_height;
  logic [CB:0] w_eff;
  logic [RB-1:0] h_eff;
  logic [23:0] upper_mem [sobel_pkg::MaxWidth];
  logic [23:0] middle_mem [sobel_pkg::MaxWidth];
  logic [23:0] top_rd, mid_rd, px_hold;
  logic [23:0] top_q, mid_q, byp_top, byp_mid;
  logic byp;
  logic [8:0][23:0] window;
  logic [CB-1:0] col;
  logic [RB-1:0] row;
  logic [CB-1:0] col_s1;
  logic [RB-1:0] row_s1;
  logic s1_valid;
  logic [23:0] px;
  logic adv;
  logic [CB-1:0] oj;
  logic [RB-1:0] oi;
  logic emit, last;
  logic [8:0][23:0] nb;
  logic [8:0][23:0] win_next;

  always_comb begin
    w_eff = (image_width == '0) ? (CB+1)'(1) :
            (image_width > sobel_pkg::CfgBits'(sobel_pkg::MaxWidth)) ?
            (CB+1)'(sobel_pkg::MaxWidth) : (CB+1)'(image_width);
    h_eff = (image_height == '0) ? RB'(1) :
            (image_height > sobel_pkg::CfgBits'(sobel_pkg::MaxHeight)) ?
            RB'(sobel_pkg::MaxHeight) : RB'(image_height);
  end

  assign in_stall = s1_valid && job_valid && job_stall;
  assign adv = in_valid && !in_stall;
  assign px = in_data.drain ? 24'd0 :
              {in_data.pixel_red, in_data.pixel_green, in_data.pixel_blue};

  // same column as the item still in the write stage: take its values
  assign top_rd = byp ? byp_top : top_q;
  assign mid_rd = byp ? byp_mid : mid_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      top_q <= upper_mem[col];
      mid_q <= middle_mem[col];
      byp <= s1_valid && col_s1 == col;
      byp_top <= mid_rd;
      byp_mid <= px_hold;
      px_hold <= px;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && !(job_valid && job_stall)) begin
      upper_mem[col_s1] <= mid_rd;
      middle_mem[col_s1] <= px_hold;
    end
  end

  logic last_in;
  always_comb begin
    last_in = (row == h_eff + RB'(1)) && (col == '0);
  end

  // counters follow the item order; an emitted last pixel, a reset or a size write restarts them
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= sobel_pkg::CfgBits'(1024);
      image_height <= sobel_pkg::CfgBits'(1024);
      col <= '0;
      row <= '0;
    end else if (cfg_write && cfg_index == sobel_pkg::RegWidth) begin
      image_width <= cfg_data;
      col <= '0;
      row <= '0;
    end else if (cfg_write && cfg_index == sobel_pkg::RegHeight) begin
      image_height <= cfg_data;
      col <= '0;
      row <= '0;
    end else if (adv) begin
      if (last_in) begin
        col <= '0;
        row <= '0;
      end else if ((CB+1)'(col) + (CB+1)'(1) >= w_eff) begin
        col <= '0;
        row <= row + RB'(1);
      end else begin
        col <= col + CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_s1 <= col;
      row_s1 <= row;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      win_next[a*3] = window[a*3+1];
      win_next[a*3+1] = window[a*3+2];
    end
    win_next[2] = top_rd;
    win_next[5] = mid_rd;
    win_next[8] = px_hold;
    emit = (row_s1 >= RB'(2)) || (row_s1 == RB'(1) && col_s1 != '0);
    if (col_s1 != '0) begin
      oi = row_s1 - RB'(1);
      oj = col_s1 - CB'(1);
    end else begin
      oi = row_s1 - RB'(2);
      oj = CB'(w_eff - (CB+1)'(1));
    end
    for (int a = 0; a < 9; a++) begin
      nb[a] = ((a / 3 == 0 && oi == '0) ||
               (a / 3 == 2 && (RB+1)'(oi) + (RB+1)'(1) >= (RB+1)'(h_eff)) ||
               (a % 3 == 0 && oj == '0) ||
               (a % 3 == 2 && (CB+1)'(oj) + (CB+1)'(1) >= w_eff)) ? 24'd0 : win_next[a];
    end
    last = ((RB+1)'(oi) + (RB+1)'(1) >= (RB+1)'(h_eff)) &&
           ((CB+1)'(oj) + (CB+1)'(1) >= w_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      job_valid <= 1'b0;
    end else if (!(job_valid && job_stall)) begin
      job_valid <= s1_valid && emit;
      if (s1_valid) begin
        window <= win_next;
        job.nb <= nb;
        job.last <= last;
      end
    end
  end
endmodule

/* src/sobel_fifo.sv */
// short queue between front and back end
module sobel_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  input  sobel_pkg::job_t wr_data,
  output logic            wr_stall,
  output logic            rd_valid,
  output sobel_pkg::job_t rd_data,
  input  logic            rd_stall
);
  sobel_pkg::job_t slot [2];
  logic [1:0] count;
  logic wptr, rptr, push, pop;

  assign wr_stall = count == 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data = slot[rptr];
  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

/* src/sobel_back.sv */
// back end: gradients, squared sums, pipelined rounded square root
module sobel_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  sobel_pkg::job_t job,
  output logic            job_stall,
  output logic            out_valid,
  output sobel_pkg::out_t out_data,
  input  logic            out_stall
);
  localparam int Steps = 11;

  logic [Steps:0] v;
  logic [20:0] rem [Steps][3];
  logic [20:0] q [Steps][3];
  logic last [Steps];
  logic adv;
  logic [20:0] sq [3];

  assign adv = !(out_valid && out_stall);
  assign job_stall = !adv;

  function automatic logic [20:0] mag2(input logic [8:0][23:0] nb, input int sh);
    logic signed [11:0] gx, gy;
    logic signed [11:0] p [9];
    logic signed [21:0] ex, ey;
    for (int a = 0; a < 9; a++) p[a] = 12'($unsigned(nb[a][sh +: 8]));
    gx = p[2] - p[0] + 12'sd2 * (p[5] - p[3]) + p[8] - p[6];
    gy = p[6] - p[0] + 12'sd2 * (p[7] - p[1]) + p[8] - p[2];
    ex = 22'(gx);
    ey = 22'(gy);
    return 21'($unsigned(ex * ex + ey * ey));
  endfunction

  always_comb begin
    sq[0] = mag2(job.nb, 16);
    sq[1] = mag2(job.nb, 8);
    sq[2] = mag2(job.nb, 0);
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (adv) v <= {v[Steps-1:0], job_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last[0] <= job.last;
      for (int c = 0; c < 3; c++) begin
        rem[0][c] <= sq[c];
        q[0][c] <= '0;
      end
      for (int k = 0; k < Steps - 1; k++) begin
        last[k+1] <= last[k];
        for (int c = 0; c < 3; c++) begin
          logic [20:0] b;
          b = 21'(1) << (2 * (9 - k));
          if (rem[k][c] >= q[k][c] + b) begin
            rem[k+1][c] <= rem[k][c] - q[k][c] - b;
            q[k+1][c] <= (q[k][c] >> 1) + b;
          end else begin
            rem[k+1][c] <= rem[k][c];
            q[k+1][c] <= q[k][c] >> 1;
          end
        end
      end
    end
  end

  logic [20:0] qf [3];
  logic [7:0] res [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qf[c] = q[Steps-1][c] + 21'(rem[Steps-1][c] > q[Steps-1][c]);
      res[c] = (qf[c] > 21'd255) ? 8'd255 : qf[c][7:0];
    end
  end

  assign out_valid = v[Steps];
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= {res[0], res[1], res[2], last[Steps-1]};
    end
  end
endmodule

/* src/sobel_edge_magnitude_rgb.sv */
// top level of the rgb sobel edge magnitude block
//  channel | valid    | stall     | payload
//  in      | in_valid | in_stall  | in_data  (sobel_pkg::in_t)
//  out     | out_valid| out_stall | out_data (sobel_pkg::out_t)
//  cfg     | cfg_write| -         | cfg_index, cfg_data
// one pixel per cycle while in_stall is low; out_valid follows the transfer that completes a window
// path: line store read, job register, queue slot, 11 root stages, output register
// rst is synchronous; line stores are not cleared, padding masks stale data
// an output stall backs up through a two-entry queue to the input
module sobel_edge_magnitude_rgb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [sobel_pkg::CfgBits-1:0] cfg_data,
  input  logic                          in_valid,
  input  sobel_pkg::in_t                in_data,
  output logic                          in_stall,
  output logic                          out_valid,
  output sobel_pkg::out_t               out_data,
  input  logic                          out_stall
);
  logic fj_valid, fj_stall, bj_valid, bj_stall;
  sobel_pkg::job_t fj, bj;

  sobel_front u_front (.clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_data, .in_stall, .job_valid(fj_valid), .job(fj),
    .job_stall(fj_stall));
  sobel_fifo u_fifo (.clk, .rst, .wr_valid(fj_valid), .wr_data(fj),
    .wr_stall(fj_stall), .rd_valid(bj_valid), .rd_data(bj), .rd_stall(bj_stall));
  sobel_back u_back (.clk, .rst, .job_valid(bj_valid), .job(bj),
    .job_stall(bj_stall), .out_valid, .out_data, .out_stall);
endmodule

/* src/sobel_checker.sv */
// port checker for the sobel block and its bind
module sobel_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_stall,
  input logic            out_valid,
  input sobel_pkg::out_t out_data,
  input logic            out_stall
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output changed");
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");
endmodule

bind sobel_edge_magnitude_rgb sobel_checker u_checker (.clk, .rst,
  .in_stall, .out_valid, .out_data, .out_stall);

/* sim/sobel_edge_magnitude_rgb_tb.sv */
// testbench for the rgb sobel edge magnitude block: directed and random frames
module sobel_edge_magnitude_rgb_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;
  localparam int SettleCycles = 40;
  localparam int ItemTarget = 1400;
  localparam logic [1:0] RegSpare2 = 2'd2;
  localparam logic [1:0] RegSpare3 = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [sobel_pkg::CfgBits-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  sobel_pkg::in_t in_data = '0;
  logic in_stall;
  logic out_valid;
  sobel_pkg::out_t out_data;
  logic out_stall = 1'b0;

  sobel_edge_magnitude_rgb i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_data(in_data),
    .in_stall(in_stall), .out_valid(out_valid), .out_data(out_data),
    .out_stall(out_stall)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [sobel_pkg::CfgBits-1:0] width_reg = 11'd1024;
  logic [sobel_pkg::CfgBits-1:0] height_reg = 11'd1024;
  logic [23:0] upper_row [sobel_pkg::MaxWidth];
  logic [23:0] middle_row [sobel_pkg::MaxWidth];
  logic [23:0] win [9];
  int col_pos = 0;
  int row_pos = 0;
  sobel_pkg::out_t edge_queue [$];

  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;
  bit out_fire = 1'b0;
  int stall_left = 0;

  function automatic int eff_dim(logic [sobel_pkg::CfgBits-1:0] v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [7:0] rounded_mag(logic [23:0] nb [9], int sh);
    int gx, gy, s, q;
    logic [7:0] v [9];
    for (int k = 0; k < 9; k++) v[k] = nb[k][sh +: 8];
    gx = -v[0] + v[2] - 2 * v[3] + 2 * v[5] - v[6] + v[8];
    gy = -v[0] - 2 * v[1] - v[2] + v[6] + 2 * v[7] + v[8];
    s = gx * gx + gy * gy;
    q = 0;
    while (q < 256 && (q + 1) * (q + 1) <= s) q++;
    if (q >= 256) return 8'd255;
    if (s > q * q + q) q++;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic void predict_edge(sobel_pkg::in_t d);
    int w, h, c, r, oi, oj, rr, cc;
    logic [23:0] px, top, mid;
    logic [23:0] nb [9];
    bit zero;
    sobel_pkg::out_t e;
    w = eff_dim(width_reg, sobel_pkg::MaxWidth);
    h = eff_dim(height_reg, sobel_pkg::MaxHeight);
    c = col_pos;
    r = row_pos;
    px = d.drain ? 24'd0 : {d.pixel_red, d.pixel_green, d.pixel_blue};
    if (c >= w) c = 0;
    top = upper_row[c];
    mid = middle_row[c];
    upper_row[c] = mid;
    middle_row[c] = px;
    for (int a = 0; a < 3; a++) begin
      win[a * 3] = win[a * 3 + 1];
      win[a * 3 + 1] = win[a * 3 + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    if (c >= 1) begin
      oi = r - 1;
      oj = c - 1;
    end else begin
      oi = r - 2;
      oj = w - 1;
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    if (!(r >= 2 || (r == 1 && c >= 1))) return;
    for (int a = 0; a < 9; a++) begin
      rr = a / 3;
      cc = a % 3;
      zero = (rr == 0 && oi == 0) || (rr == 2 && oi + 1 >= h) ||
             (cc == 0 && oj == 0) || (cc == 2 && oj + 1 >= w);
      nb[a] = zero ? 24'd0 : win[a];
    end
    e.edge_red = rounded_mag(nb, 16);
    e.edge_green = rounded_mag(nb, 8);
    e.edge_blue = rounded_mag(nb, 0);
    e.frame_end = (oi + 1 >= h) && (oj + 1 >= w);
    edge_queue.push_back(e);
    if (e.frame_end) begin
      col_pos = 0;
      row_pos = 0;
    end
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result check, sampled mid-cycle
  always @(negedge clk) begin
    sobel_pkg::out_t e;
    out_fire = 1'b0;
    if (!rst && out_valid && !out_stall) begin
      out_fire = 1'b1;
      if (edge_queue.size() == 0) begin
        $error("unexpected transfer %h", out_data);
        errors++;
      end else begin
        e = edge_queue.pop_front();
        if (out_data.edge_red !== e.edge_red) begin
          $error("edge_red exp %0d got %0d", e.edge_red, out_data.edge_red);
          errors++;
        end
        if (out_data.edge_green !== e.edge_green) begin
          $error("edge_green exp %0d got %0d", e.edge_green, out_data.edge_green);
          errors++;
        end
        if (out_data.edge_blue !== e.edge_blue) begin
          $error("edge_blue exp %0d got %0d", e.edge_blue, out_data.edge_blue);
          errors++;
        end
        if (out_data.frame_end !== e.frame_end) begin
          $error("frame_end exp %0d got %0d", e.frame_end, out_data.frame_end);
          errors++;
        end
      end
    end
  end

  // output stall
  always @(posedge clk) begin
    if (out_fire) stall_left = out_quiet ? 0 : $urandom_range(0, 5);
    out_stall <= (stall_left != 0);
    if (stall_left > 0) stall_left--;
  end

  task automatic send_item(sobel_pkg::in_t d);
    int gap;
    bit stalled;
    gap = in_quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    predict_edge(d);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (edge_queue.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [sobel_pkg::CfgBits-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == sobel_pkg::RegWidth) width_reg = val;
    else if (idx == sobel_pkg::RegHeight) height_reg = val;
    if (idx == sobel_pkg::RegWidth || idx == sobel_pkg::RegHeight) begin
      col_pos = 0;
      row_pos = 0;
    end
    @(posedge clk);
  endtask

  function automatic sobel_pkg::in_t rand_pixel(int noise_pct);
    sobel_pkg::in_t d;
    d.pixel_red = 8'($urandom);
    d.pixel_green = 8'($urandom);
    d.pixel_blue = 8'($urandom);
    d.drain = ($urandom_range(0, 99) < noise_pct);
    return d;
  endfunction

  // full frame plus flush; with noise_pct above zero, some flush items carry a live pixel
  task automatic run_frame(int noise_pct);
    int n;
    sobel_pkg::in_t d;
    n = eff_dim(width_reg, sobel_pkg::MaxWidth) * eff_dim(height_reg, sobel_pkg::MaxHeight);
    for (int k = 0; k < n; k++) send_item(rand_pixel(noise_pct));
    for (int k = 0; k <= eff_dim(width_reg, sobel_pkg::MaxWidth); k++) begin
      d = rand_pixel(0);
      d.drain = ($urandom_range(0, 99) >= noise_pct);
      send_item(d);
    end
  endtask

  task automatic test_directed();
    sobel_pkg::in_t d;
    write_reg(sobel_pkg::RegWidth, 11'd3);
    write_reg(sobel_pkg::RegHeight, 11'd3);
    for (int k = 0; k < 9; k++) begin
      d = '0;
      if ((k % 2) == 0) {d.pixel_red, d.pixel_green, d.pixel_blue} = 24'hffffff;
      else d.pixel_green = 8'hff;
      d.drain = (k == 4);
      send_item(d);
    end
    for (int k = 0; k < 4; k++) begin
      d = '1;
      d.drain = (k != 1);
      send_item(d);
    end
    wait_idle();
  endtask

  task automatic test_extremes();
    write_reg(sobel_pkg::RegWidth, 11'd0);
    write_reg(sobel_pkg::RegHeight, 11'd2047);
    run_frame(3);
    wait_idle();
    write_reg(sobel_pkg::RegWidth, 11'd4);
    write_reg(sobel_pkg::RegHeight, 11'd0);
    write_reg(RegSpare2, 11'd5);
    write_reg(RegSpare3, 11'd1365);
    run_frame(0);
    wait_idle();
  endtask

  task automatic test_restart();
    write_reg(sobel_pkg::RegWidth, 11'd5);
    write_reg(sobel_pkg::RegHeight, 11'd4);
    for (int k = 0; k < 9; k++) send_item(rand_pixel(0));
    wait_idle();
    write_reg(sobel_pkg::RegHeight, 11'd4);
    run_frame(5);
    wait_idle();
  endtask

  task automatic test_random();
    while (items_sent < ItemTarget) begin
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      write_reg(sobel_pkg::RegWidth, 11'($urandom_range(1, 16)));
      write_reg(sobel_pkg::RegHeight, 11'($urandom_range(1, 10)));
      repeat ($urandom_range(1, 3)) run_frame($urandom_range(0, 1) ? 0 : 5);
      wait_idle();
    end
  endtask

  initial begin
    for (int k = 0; k < sobel_pkg::MaxWidth; k++) begin
      upper_row[k] = '0;
      middle_row[k] = '0;
    end
    for (int k = 0; k < 9; k++) win[k] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extremes();
    test_restart();
    test_random();
    wait_idle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

/* sobel_edge_magnitude_rgb.f */
src/sobel_pkg.sv
src/sobel_front.sv
src/sobel_fifo.sv
src/sobel_back.sv
src/sobel_edge_magnitude_rgb.sv
src/sobel_checker.sv
sim/sobel_edge_magnitude_rgb_tb.sv
